// ===== hw/rtl/timed_wakeup_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Timed wake-up queue assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_WAKEUP_QUEUE_ASSERT_SVH
`define TIMED_WAKEUP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// implication check
`define TWQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed_wakeup_queue: implication check failed");
// invariant check
`define TWQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("timed_wakeup_queue: invariant check failed");
`else
`define TWQ_ASSERT_IMP(lbl, ante, cons)
`define TWQ_ASSERT_ALWAYS(lbl, expr)
`endif
`endif

// ===== hw/rtl/twq_pkg.sv =====
// ----------------------------------------------------------------------------
// twq_pkg
// Shared constants, types and helpers of the timed wake-up queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package twq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_BITS     = 6;
    localparam int MAX_RESULTS = 32;
    localparam int TIME_BITS   = 48;
    localparam int DELAY_BITS  = 32;
    localparam int AW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_QUEUED  = 3'd0,
        ST_IGNORED = 3'd1,
        ST_FULL    = 3'd2,
        ST_WOKEN   = 3'd3,
        ST_NONE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_IGNORE = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_kind_t;

    // classified word passed from front to back
    typedef struct packed {
        cmd_kind_t              kind;
        logic [ID_BITS-1:0]     id;
        logic [TIME_BITS-1:0]   tval;   // wake time for insert, now for tick
    } cmd_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic [CW-1:0] count;
        logic          idle;
    } back_stat_t;

    // physical slot of a logical position in the circular store
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (AW+1)'(QUEUE_DEPTH))
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        return sum[AW-1:0];
    endfunction

endpackage

// ===== hw/rtl/twq_front.sv =====
// ----------------------------------------------------------------------------
// twq_front
// Accepts request words, classifies them and computes saturated wake times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module twq_front import twq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         mode,
    input  logic [ID_BITS-1:0]           thread_id,
    input  logic signed [DELAY_BITS-1:0] sleep_ticks,
    input  logic [TIME_BITS-1:0]         now_tick,
    output logic                         busy,
    output logic                         cmd_valid,
    output cmd_t                         cmd,
    input  logic                         cmd_take
);

    logic       valid_reg, valid_next;
    cmd_t       cmd_reg, cmd_next;
    logic       accept;
    logic [TIME_BITS:0] sum;

    assign busy      = valid_reg && !cmd_take;
    assign accept    = start && !busy;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // classify and saturate the wake time
    always_comb
    begin
        sum = {1'b0, now_tick} + {{(TIME_BITS-DELAY_BITS+1){1'b0}}, sleep_ticks};
        cmd_next.id = thread_id;
        if (mode)
        begin
            cmd_next.kind = CMD_TICK;
            cmd_next.tval = now_tick;
        end
        else if (sleep_ticks <= 0)
        begin
            cmd_next.kind = CMD_IGNORE;
            cmd_next.tval = now_tick;
        end
        else
        begin
            cmd_next.kind = CMD_INSERT;
            cmd_next.tval = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
        end
        valid_next = accept || (valid_reg && !cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

// ===== hw/rtl/twq_fifo.sv =====
// ----------------------------------------------------------------------------
// twq_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module twq_fifo import twq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_word,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_word
);

    cmd_t       buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_word = buf_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== hw/rtl/twq_back.sv =====
// ----------------------------------------------------------------------------
// twq_back
// Sorted circular store: tail-first insertion walk and head-first wake walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module twq_back import twq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_empty,
    input  cmd_t               cmd_in,
    output logic               cmd_pop,
    output logic               done,
    output logic [2:0]         status,
    output logic [ID_BITS-1:0] woken_id,
    output logic               last,
    output back_stat_t         stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_INS_WAIT, S_INS_PUT, S_TICK_WAIT, S_TICK_END
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [NW-1:0]      nwoke_reg, nwoke_next;
    logic               pend_reg, pend_next;
    logic [ID_BITS-1:0] pend_id_reg, pend_id_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [ID_BITS-1:0] wid_reg, wid_next;
    logic               last_reg, last_next;

    // store and its port controls
    logic [TIME_BITS-1:0] time_mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   id_mem   [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] rd_time_reg;
    logic [ID_BITS-1:0]   rd_id_reg;
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [TIME_BITS-1:0] wr_time;
    logic [ID_BITS-1:0]   wr_id;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_time;
            id_mem[wr_addr]   <= wr_id;
        end
        if (rd_en)
        begin
            rd_time_reg <= time_mem[rd_addr];
            rd_id_reg   <= id_mem[rd_addr];
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign woken_id   = wid_reg;
    assign last       = last_reg;
    assign stat.count = count_reg;
    assign stat.idle  = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        nwoke_next   = nwoke_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        wid_next     = '0;
        last_next    = 1'b1;
        cmd_pop      = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_time      = rd_time_reg;
        wr_id        = rd_id_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                    case (cmd_in.kind)
                        CMD_IGNORE:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_IGNORED;
                        end
                        CMD_INSERT:
                        begin
                            if (count_reg >= CW'(QUEUE_DEPTH))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                // read the tail entry
                                rd_en      = 1'b1;
                                rd_addr    = slot_of(head_reg, AW'(count_reg - 1'b1));
                                pos_next   = count_reg;
                                state_next = S_INS_WAIT;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                nwoke_next = '0;
                                pend_next  = 1'b0;
                                state_next = S_TICK_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_WAIT:
            begin
                // entry at pos-1 is in the read register
                if (rd_time_reg >= cmd_reg.tval)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = slot_of(head_reg, AW'(pos_reg));
                    pos_next = pos_reg - 1'b1;
                    if (pos_reg == CW'(1))
                        state_next = S_INS_PUT;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = slot_of(head_reg, AW'(pos_reg - CW'(2)));
                    end
                end
                else
                    state_next = S_INS_PUT;
            end
            S_INS_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = slot_of(head_reg, AW'(pos_reg));
                wr_time     = cmd_reg.tval;
                wr_id       = cmd_reg.id;
                count_next  = count_reg + 1'b1;
                done_next   = 1'b1;
                status_next = ST_QUEUED;
                state_next  = S_IDLE;
            end
            S_TICK_WAIT:
            begin
                // head entry is in the read register
                if (rd_time_reg <= cmd_reg.tval)
                begin
                    if (pend_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_WOKEN;
                        wid_next    = pend_id_reg;
                        last_next   = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = rd_id_reg;
                    head_next    = slot_of(head_reg, AW'(1));
                    count_next   = count_reg - 1'b1;
                    nwoke_next   = nwoke_reg + 1'b1;
                    if (count_reg != CW'(1) && nwoke_reg != NW'(MAX_RESULTS - 1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = slot_of(head_reg, AW'(1));
                    end
                    else
                        state_next = S_TICK_END;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = pend_reg ? ST_WOKEN : ST_NONE;
                    wid_next    = pend_reg ? pend_id_reg : '0;
                    state_next  = S_IDLE;
                end
            end
            S_TICK_END:
            begin
                done_next   = 1'b1;
                status_next = ST_WOKEN;
                wid_next    = pend_id_reg;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_NONE;
            wid_reg    <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            wid_reg    <= wid_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        pos_reg     <= pos_next;
        nwoke_reg   <= nwoke_next;
        pend_id_reg <= pend_id_next;
    end

endmodule

// ===== hw/rtl/timed_wakeup_queue.sv =====
// ----------------------------------------------------------------------------
// timed_wakeup_queue
// Wake-up queue sorted by absolute wake time, with sleep and tick commands.
// ----------------------------------------------------------------------------
//  channel  | handshake           | words
//  request  | start, busy         | mode, thread_id, sleep_ticks, now_tick
//  result   | done (one cycle)    | status, woken_id, last
//
// A sleep word holds the back end while the insertion walk moves entries,
// and a tick while the wake walk reads woken entries, both set by the
// single read port of the store. Two words can wait in the command queue.
// Reset is asynchronous and empties the store. Results cannot be stalled:
// each is on the ports for one cycle with done high.
`timescale 1ns / 1ps
`include "timed_wakeup_queue_assert.svh"
module timed_wakeup_queue import twq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic [ID_BITS-1:0]           thread_id,
    input  logic signed [DELAY_BITS-1:0] sleep_ticks,
    input  logic [TIME_BITS-1:0]         now_tick,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [ID_BITS-1:0]           woken_id,
    output logic                         last
);

    logic       cmd_valid, fifo_full, fifo_empty, fifo_pop;
    cmd_t       front_cmd, fifo_cmd;
    back_stat_t stat;

    twq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .thread_id   (thread_id),
        .sleep_ticks (sleep_ticks),
        .now_tick    (now_tick),
        .busy        (busy),
        .cmd_valid   (cmd_valid),
        .cmd         (front_cmd),
        .cmd_take    (!fifo_full)
    );

    twq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid && !fifo_full),
        .push_word (front_cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .empty     (fifo_empty),
        .pop_word  (fifo_cmd)
    );

    twq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (fifo_empty),
        .cmd_in    (fifo_cmd),
        .cmd_pop   (fifo_pop),
        .done      (done),
        .status    (status),
        .woken_id  (woken_id),
        .last      (last),
        .stat      (stat)
    );

    // only woken results carry an id, and only they may be non-final
    `TWQ_ASSERT_IMP(a_id_only_woken, done && status != ST_WOKEN, woken_id == '0 && last)
    // store never holds more than its depth
    `TWQ_ASSERT_ALWAYS(a_count_bound, stat.count <= CW'(QUEUE_DEPTH))
    // a non-final result is always followed by another result
    `TWQ_ASSERT_IMP(a_burst_cont, done && !last, ##1 done)
    // a full-queue report only with a full store
    `TWQ_ASSERT_IMP(a_full_report, done && status == ST_FULL, stat.count == CW'(QUEUE_DEPTH))
    // the back end takes a queued word only when idle
    `TWQ_ASSERT_IMP(a_pop_idle, fifo_pop, stat.idle && !fifo_empty)

endmodule
